FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDN_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rdn assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RDN_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rdn assertion failed");

`endif

FILE: rtl/rdn_pkg.sv
// Package: widths, constants, types and helpers for the radial dead zone normalizer.
`timescale 1ns / 1ps

package rdn_pkg;

    localparam int OUT_FRAC_BITS = 15;
    localparam int LEN_FRAC      = 8;

    localparam int MAG_W   = 16;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int RAD_W   = SQ_W + 2 * LEN_FRAC;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int DZ_W    = 15;
    localparam int DZSQ_W  = 2 * DZ_W;
    localparam int EXC_W   = ROOT_W;
    localparam int DEN_W   = ROOT_W + DZ_W;
    localparam int PROD_W  = MAG_W + EXC_W;
    localparam int DIVD_W  = PROD_W + OUT_FRAC_BITS + 2;
    localparam int DIVR_W  = DEN_W + 1;
    localparam int Q_W     = OUT_FRAC_BITS + 2;
    localparam int OUT_W   = 16;
    localparam int TRIG_W  = 8;
    localparam int TOUT_W  = 15;
    localparam int CAP_W   = 15;
    localparam int CFG_IDX_W = 2;

    localparam logic [DZ_W-1:0]  STICK_FS = 15'd32767;
    localparam logic [DZ_W-1:0]  TRIG_FS  = 15'd255;
    localparam logic [CAP_W-1:0] OUT_CAP  = 15'd32767;

    localparam logic [DZ_W-1:0]   DZ_A_RST = 15'd7849;
    localparam logic [DZ_W-1:0]   DZ_B_RST = 15'd8689;
    localparam logic [TRIG_W-1:0] DZ_T_RST = 8'd30;

    // square stage, length-squared stage, root steps, three scaling stages, divide steps, format stage
    localparam int LANE_LAT = 2 + ROOT_W + 3 + Q_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STICK_A = 2'd0,
        REG_STICK_B = 2'd1,
        REG_TRIGGER = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
        logic             nx;
        logic             ny;
        logic             live;
    } side_t;

    typedef struct packed {
        logic nx;
        logic ny;
        logic live;
    } flags_t;

    // magnitude of a 16-bit two's complement value; -32768 gives 32768
    function automatic logic [MAG_W-1:0] abs16(input logic [MAG_W-1:0] v);
        abs16 = v[MAG_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

FILE: rtl/rdn_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module rdn_sqrt (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [rdn_pkg::RAD_W-1:0]   rad,
    output logic [rdn_pkg::ROOT_W-1:0]  root
);

    localparam int STEPS = rdn_pkg::ROOT_W;

    logic [rdn_pkg::RAD_W-1:0]  rad_reg  [STEPS-1];
    logic [rdn_pkg::REM_W-1:0]  rem_reg  [STEPS-1];
    logic [rdn_pkg::ROOT_W-1:0] root_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [rdn_pkg::RAD_W-1:0]  rad_in;
        logic [rdn_pkg::REM_W-1:0]  rem_in;
        logic [rdn_pkg::REM_W-1:0]  rem_sh;
        logic [rdn_pkg::REM_W-1:0]  trial;
        logic [rdn_pkg::ROOT_W-1:0] root_in;
        logic                       take;

        if (k == 0) begin : g_first
            assign rad_in  = rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // bring down the next two radicand bits, try 4*root+1
        assign rem_sh = {rem_in[rdn_pkg::REM_W-3:0], rad_in[rdn_pkg::RAD_W-1-2*k -: 2]};
        assign trial  = rdn_pkg::REM_W'({root_in, 2'b01});
        assign take   = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= {root_in[rdn_pkg::ROOT_W-2:0], take};
            end
        end

        if (k < STEPS - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[k] <= rad_in;
                    rem_reg[k] <= take ? (rem_sh - trial) : rem_sh;
                end
            end
        end
    end

    assign root = root_reg[STEPS-1];

endmodule

FILE: rtl/rdn_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module rdn_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [rdn_pkg::DIVD_W-1:0]  dividend,
    input  logic [rdn_pkg::DIVR_W-1:0]  divisor,
    output logic [rdn_pkg::Q_W-1:0]     quot
);

    localparam int STEPS = rdn_pkg::Q_W;

    logic [rdn_pkg::DIVD_W-1:0] rem_reg [STEPS-1];
    logic [rdn_pkg::DIVR_W-1:0] d_reg   [STEPS-1];
    logic [rdn_pkg::Q_W-1:0]    q_reg   [STEPS];

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        localparam int SH = STEPS - 1 - j;
        logic [rdn_pkg::DIVD_W-1:0] rem_in;
        logic [rdn_pkg::DIVR_W-1:0] d_in;
        logic [rdn_pkg::Q_W-1:0]    q_in;
        logic [rdn_pkg::DIVD_W-1:0] dsh;
        logic                       ge;

        if (j == 0) begin : g_first
            assign rem_in = dividend;
            assign d_in   = divisor;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = rem_reg[j-1];
            assign d_in   = d_reg[j-1];
            assign q_in   = q_reg[j-1];
        end

        assign dsh = rdn_pkg::DIVD_W'(d_in) << SH;
        assign ge  = (rem_in >= dsh);

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[j] <= {q_in[rdn_pkg::Q_W-2:0], ge};
            end
        end

        if (j < STEPS - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= ge ? (rem_in - dsh) : rem_in;
                    d_reg[j]   <= d_in;
                end
            end
        end
    end

    assign quot = q_reg[STEPS-1];

endmodule

FILE: rtl/rdn_lane.sv
// One pair lane: dead zone test, vector length, radial rescale of both axes.
`timescale 1ns / 1ps

module rdn_lane (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [rdn_pkg::MAG_W-1:0]   mag_x,
    input  logic [rdn_pkg::MAG_W-1:0]   mag_y,
    input  logic                        neg_x,
    input  logic                        neg_y,
    input  logic [rdn_pkg::DZ_W-1:0]    dz,
    input  logic [rdn_pkg::DZ_W-1:0]    fs,
    output logic [rdn_pkg::OUT_W-1:0]   out_x,
    output logic [rdn_pkg::OUT_W-1:0]   out_y
);

    localparam int F = rdn_pkg::OUT_FRAC_BITS;

    // stage 1: squares
    logic [rdn_pkg::MAG_W-1:0]  mx1_reg, my1_reg;
    logic                       nx1_reg, ny1_reg;
    logic [rdn_pkg::SQ_W-1:0]   sqx_reg, sqy_reg;
    logic [rdn_pkg::DZSQ_W-1:0] dzsq_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mx1_reg  <= mag_x;
            my1_reg  <= mag_y;
            nx1_reg  <= neg_x;
            ny1_reg  <= neg_y;
            sqx_reg  <= rdn_pkg::SQ_W'(mag_x * mag_x);
            sqy_reg  <= rdn_pkg::SQ_W'(mag_y * mag_y);
            dzsq_reg <= rdn_pkg::DZSQ_W'(dz * dz);
        end
    end

    // stage 2: length squared and dead zone test
    logic [rdn_pkg::SQ_W-1:0] sq_sum;
    logic [rdn_pkg::SQ_W-1:0] sq_reg;
    rdn_pkg::side_t           side2_reg;

    assign sq_sum = sqx_reg + sqy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg         <= sq_sum;
            side2_reg.mx   <= mx1_reg;
            side2_reg.my   <= my1_reg;
            side2_reg.nx   <= nx1_reg;
            side2_reg.ny   <= ny1_reg;
            side2_reg.live <= (dz < fs) && (sq_sum > rdn_pkg::SQ_W'(dzsq_reg));
        end
    end

    // length with 8 fraction bits
    logic [rdn_pkg::RAD_W-1:0]  rad;
    logic [rdn_pkg::ROOT_W-1:0] lq;

    assign rad = {sq_reg, {(2*rdn_pkg::LEN_FRAC){1'b0}}};

    rdn_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (rad),
        .root (lq)
    );

    rdn_pkg::side_t sd_reg [rdn_pkg::ROOT_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0] <= side2_reg;
            for (int i = 1; i < rdn_pkg::ROOT_W; i++) begin
                sd_reg[i] <= sd_reg[i-1];
            end
        end
    end

    // stage A: clipped excess and denominator
    logic [rdn_pkg::EXC_W-1:0] fs_l, dz_l, lc;
    logic [rdn_pkg::DZ_W-1:0]  span;
    logic [rdn_pkg::EXC_W-1:0] exc_reg;
    logic [rdn_pkg::DEN_W-1:0] den_a_reg;
    rdn_pkg::side_t            sa_reg;

    assign fs_l = rdn_pkg::EXC_W'({fs, {rdn_pkg::LEN_FRAC{1'b0}}});
    assign dz_l = rdn_pkg::EXC_W'({dz, {rdn_pkg::LEN_FRAC{1'b0}}});
    assign lc   = (lq < fs_l) ? lq : fs_l;
    assign span = fs - dz;

    always_ff @(posedge aclk) begin
        if (en) begin
            exc_reg   <= lc - dz_l;
            den_a_reg <= rdn_pkg::DEN_W'(lq * span);
            sa_reg    <= sd_reg[rdn_pkg::ROOT_W-1];
        end
    end

    // stage B: axis numerators
    logic [rdn_pkg::PROD_W-1:0] prodx_reg, prody_reg;
    logic [rdn_pkg::DEN_W-1:0]  den_b_reg;
    rdn_pkg::flags_t            fb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prodx_reg   <= rdn_pkg::PROD_W'(sa_reg.mx * exc_reg);
            prody_reg   <= rdn_pkg::PROD_W'(sa_reg.my * exc_reg);
            den_b_reg   <= den_a_reg;
            fb_reg.nx   <= sa_reg.nx;
            fb_reg.ny   <= sa_reg.ny;
            fb_reg.live <= sa_reg.live;
        end
    end

    // stage C: round-to-nearest operands, (2*num + den) / (2*den)
    logic [rdn_pkg::DIVD_W-1:0] divdx_reg, divdy_reg;
    logic [rdn_pkg::DIVR_W-1:0] divr_reg;
    rdn_pkg::flags_t            fc_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            divdx_reg <= rdn_pkg::DIVD_W'({prodx_reg, {(F+1){1'b0}}})
                       + rdn_pkg::DIVD_W'(den_b_reg);
            divdy_reg <= rdn_pkg::DIVD_W'({prody_reg, {(F+1){1'b0}}})
                       + rdn_pkg::DIVD_W'(den_b_reg);
            divr_reg  <= {den_b_reg, 1'b0};
            fc_reg    <= fb_reg;
        end
    end

    logic [rdn_pkg::Q_W-1:0] qx, qy;

    rdn_div u_div_x (
        .aclk     (aclk),
        .en       (en),
        .dividend (divdx_reg),
        .divisor  (divr_reg),
        .quot     (qx)
    );

    rdn_div u_div_y (
        .aclk     (aclk),
        .en       (en),
        .dividend (divdy_reg),
        .divisor  (divr_reg),
        .quot     (qy)
    );

    rdn_pkg::flags_t fd_reg [rdn_pkg::Q_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            fd_reg[0] <= fc_reg;
            for (int i = 1; i < rdn_pkg::Q_W; i++) begin
                fd_reg[i] <= fd_reg[i-1];
            end
        end
    end

    // format: saturate, apply sign, zero inside the dead zone
    rdn_pkg::flags_t            ff;
    logic [rdn_pkg::CAP_W-1:0]  satx, saty;
    logic [rdn_pkg::OUT_W-1:0]  ux, uy, fx, fy;
    logic [rdn_pkg::OUT_W-1:0]  out_x_reg, out_y_reg;

    always_comb begin
        ff   = fd_reg[rdn_pkg::Q_W-1];
        satx = (qx > rdn_pkg::Q_W'(rdn_pkg::OUT_CAP)) ? rdn_pkg::OUT_CAP
                                                     : qx[rdn_pkg::CAP_W-1:0];
        saty = (qy > rdn_pkg::Q_W'(rdn_pkg::OUT_CAP)) ? rdn_pkg::OUT_CAP
                                                     : qy[rdn_pkg::CAP_W-1:0];
        ux   = rdn_pkg::OUT_W'(satx);
        uy   = rdn_pkg::OUT_W'(saty);
        fx   = ff.nx ? (~ux + 1'b1) : ux;
        fy   = ff.ny ? (~uy + 1'b1) : uy;
        if (!ff.live) begin
            fx = '0;
            fy = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_x_reg <= fx;
            out_y_reg <= fy;
        end
    end

    assign out_x = out_x_reg;
    assign out_y = out_y_reg;

endmodule

FILE: rtl/radial_deadzone_normalizer.sv
// Top level: config registers, three pair lanes, valid pipeline and output merge register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  channel   direction  handshake            payload
//  s_*       in         s_valid / s_ready    connected, two stick pairs, two triggers
//  m_*       out        m_valid / m_ready    connected copy, four stick axes, two triggers
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index (register), cfg_data
//
//  One poll per cycle while s_ready is high; each transaction returns one result after
//  passing 47 lane stages (set by the 24-step root pipeline and 17-step divide pipelines)
//  and then the output register.
//  Reset (aresetn low, synchronous) empties the pipeline and loads the default dead zones.
//  A stalled m_ channel freezes the pipeline only when its last stage holds a transaction;
//  bubbles keep draining, so s_ready stays high while a result waits and the stage is empty.
//  cfg_ready is always high; each write to indices 0 to 2 goes straight into its dead zone register.

module radial_deadzone_normalizer (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_connected,
    input  logic signed [15:0]   s_stick_a_x,
    input  logic signed [15:0]   s_stick_a_y,
    input  logic signed [15:0]   s_stick_b_x,
    input  logic signed [15:0]   s_stick_b_y,
    input  logic [7:0]           s_trigger_one_raw,
    input  logic [7:0]           s_trigger_two_raw,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_connected_out,
    output logic signed [15:0]   m_stick_a_x_out,
    output logic signed [15:0]   m_stick_a_y_out,
    output logic signed [15:0]   m_stick_b_x_out,
    output logic signed [15:0]   m_stick_b_y_out,
    output logic [14:0]          m_trigger_one_out,
    output logic [14:0]          m_trigger_two_out,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [14:0]          cfg_data
);

    localparam int LAST = rdn_pkg::LANE_LAT - 1;

    // ---------------- configuration registers ----------------
    logic [rdn_pkg::DZ_W-1:0]   dz_a_reg, dz_b_reg;
    logic [rdn_pkg::TRIG_W-1:0] dz_t_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dz_a_reg <= rdn_pkg::DZ_A_RST;
            dz_b_reg <= rdn_pkg::DZ_B_RST;
            dz_t_reg <= rdn_pkg::DZ_T_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rdn_pkg::REG_STICK_A: begin
                    dz_a_reg <= cfg_data;
                end
                rdn_pkg::REG_STICK_B: begin
                    dz_b_reg <= cfg_data;
                end
                rdn_pkg::REG_TRIGGER: begin
                    dz_t_reg <= cfg_data[rdn_pkg::TRIG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic                         m_valid_reg;
    logic [rdn_pkg::LANE_LAT-1:0] vld_reg;
    logic [rdn_pkg::LANE_LAT-1:0] con_reg;
    logic                         out_load;
    logic                         adv;

    // output register free, or being emptied this cycle
    assign out_load = !m_valid_reg || m_ready;
    // pipeline may shift unless its last stage holds a result that cannot move
    assign adv      = out_load || !vld_reg[LAST];
    assign s_ready  = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAST-1:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            con_reg <= {con_reg[LAST-1:0], s_connected};
        end
    end

    // ---------------- lanes ----------------
    logic [rdn_pkg::OUT_W-1:0] a_x, a_y, b_x, b_y, t_1, t_2;

    rdn_lane u_lane_a (
        .aclk  (aclk),
        .en    (adv),
        .mag_x (rdn_pkg::abs16(s_stick_a_x)),
        .mag_y (rdn_pkg::abs16(s_stick_a_y)),
        .neg_x (s_stick_a_x[15]),
        .neg_y (s_stick_a_y[15]),
        .dz    (dz_a_reg),
        .fs    (rdn_pkg::STICK_FS),
        .out_x (a_x),
        .out_y (a_y)
    );

    rdn_lane u_lane_b (
        .aclk  (aclk),
        .en    (adv),
        .mag_x (rdn_pkg::abs16(s_stick_b_x)),
        .mag_y (rdn_pkg::abs16(s_stick_b_y)),
        .neg_x (s_stick_b_x[15]),
        .neg_y (s_stick_b_y[15]),
        .dz    (dz_b_reg),
        .fs    (rdn_pkg::STICK_FS),
        .out_x (b_x),
        .out_y (b_y)
    );

    // trigger pair: unsigned, full scale 255
    rdn_lane u_lane_t (
        .aclk  (aclk),
        .en    (adv),
        .mag_x (rdn_pkg::MAG_W'(s_trigger_one_raw)),
        .mag_y (rdn_pkg::MAG_W'(s_trigger_two_raw)),
        .neg_x (1'b0),
        .neg_y (1'b0),
        .dz    (rdn_pkg::DZ_W'(dz_t_reg)),
        .fs    (rdn_pkg::TRIG_FS),
        .out_x (t_1),
        .out_y (t_2)
    );

    // ---------------- merge / output register ----------------
    logic                       con_out_reg;
    logic [rdn_pkg::OUT_W-1:0]  ax_reg, ay_reg, bx_reg, by_reg;
    logic [rdn_pkg::TOUT_W-1:0] t1_reg, t2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= vld_reg[LAST];
        end
    end

    // a poll that was not connected answers all zeros
    always_ff @(posedge aclk) begin
        if (out_load) begin
            con_out_reg <= con_reg[LAST];
            ax_reg      <= con_reg[LAST] ? a_x : '0;
            ay_reg      <= con_reg[LAST] ? a_y : '0;
            bx_reg      <= con_reg[LAST] ? b_x : '0;
            by_reg      <= con_reg[LAST] ? b_y : '0;
            t1_reg      <= con_reg[LAST] ? t_1[rdn_pkg::TOUT_W-1:0] : '0;
            t2_reg      <= con_reg[LAST] ? t_2[rdn_pkg::TOUT_W-1:0] : '0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_connected_out   = con_out_reg;
    assign m_stick_a_x_out   = ax_reg;
    assign m_stick_a_y_out   = ay_reg;
    assign m_stick_b_x_out   = bx_reg;
    assign m_stick_b_y_out   = by_reg;
    assign m_trigger_one_out = t1_reg;
    assign m_trigger_two_out = t2_reg;

    // ---------------- assertions ----------------
    logic out_all_zero, out_no_min_neg;

    assign out_all_zero   = (ax_reg == '0) && (ay_reg == '0) && (bx_reg == '0)
                         && (by_reg == '0) && (t1_reg == '0) && (t2_reg == '0);
    assign out_no_min_neg = (ax_reg != 16'h8000) && (ay_reg != 16'h8000)
                         && (bx_reg != 16'h8000) && (by_reg != 16'h8000);

    `RDN_ASSERT_IMP(a_disc_zero, aclk, aresetn, m_valid && !m_connected_out, out_all_zero)
    `RDN_ASSERT_IMP(a_no_min_neg, aclk, aresetn, m_valid, out_no_min_neg)
    `RDN_ASSERT_IMP(a_stall_cause, aclk, aresetn, !s_ready, m_valid && !m_ready && vld_reg[LAST])
    `RDN_ASSERT_NXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, vld_reg[0])

endmodule

FILE: tb/rdn_checker.sv
// Checker: watches the poll, result and register channels, predicts each result and compares it.
`timescale 1ns / 1ps

module rdn_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_connected,
    input  logic signed [15:0] s_stick_a_x,
    input  logic signed [15:0] s_stick_a_y,
    input  logic signed [15:0] s_stick_b_x,
    input  logic signed [15:0] s_stick_b_y,
    input  logic [7:0]         s_trigger_one_raw,
    input  logic [7:0]         s_trigger_two_raw,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_connected_out,
    input  logic signed [15:0] m_stick_a_x_out,
    input  logic signed [15:0] m_stick_a_y_out,
    input  logic signed [15:0] m_stick_b_x_out,
    input  logic signed [15:0] m_stick_b_y_out,
    input  logic [14:0]        m_trigger_one_out,
    input  logic [14:0]        m_trigger_two_out,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic        conn;
        logic [15:0] ax, ay, bx, by;
        logic [14:0] t1, t2;
    } poll_result_t;

    poll_result_t expected_q[$];
    logic [14:0] dz_a, dz_b;
    logic [7:0]  dz_t;

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // one axis: rounded scaled magnitude with cap, then sign applied
    function automatic logic [15:0] axis_out(longint unsigned m, bit neg, longint unsigned exc,
                                             longint unsigned lq, longint unsigned span);
        longint unsigned num, den, q;
        num = m * exc * (64'd1 << rdn_pkg::OUT_FRAC_BITS);
        den = lq * span;
        q = (2 * num + den) / (2 * den);
        if (q > 32767) q = 32767;
        return neg ? 16'(17'h10000 - q) : 16'(q);
    endfunction

    function automatic void condition_pair(input longint unsigned mx, input bit nx,
                                           input longint unsigned my, input bit ny,
                                           input longint unsigned dz,
                                           input longint unsigned fs,
                                           output logic [15:0] ox, output logic [15:0] oy);
        longint unsigned sq, lq, lc, exc;
        ox = 0;
        oy = 0;
        sq = mx * mx + my * my;
        if (dz >= fs || sq <= dz * dz) return;
        lq = root64(sq << 16);
        lc = (lq < (fs << 8)) ? lq : (fs << 8);
        exc = lc - (dz << 8);
        ox = axis_out(mx, nx, exc, lq, fs - dz);
        oy = axis_out(my, ny, exc, lq, fs - dz);
    endfunction

    function automatic poll_result_t predict_poll();
        poll_result_t r;
        logic [15:0] x, y;
        r = '0;
        if (!s_connected) return r;
        r.conn = 1'b1;
        condition_pair(s_stick_a_x[15] ? 17'h10000 - s_stick_a_x : s_stick_a_x, s_stick_a_x[15],
                       s_stick_a_y[15] ? 17'h10000 - s_stick_a_y : s_stick_a_y, s_stick_a_y[15],
                       dz_a, 32767, r.ax, r.ay);
        condition_pair(s_stick_b_x[15] ? 17'h10000 - s_stick_b_x : s_stick_b_x, s_stick_b_x[15],
                       s_stick_b_y[15] ? 17'h10000 - s_stick_b_y : s_stick_b_y, s_stick_b_y[15],
                       dz_b, 32767, r.bx, r.by);
        condition_pair(s_trigger_one_raw, 0, s_trigger_two_raw, 0, dz_t, 255, x, y);
        r.t1 = x[14:0];
        r.t2 = y[14:0];
        return r;
    endfunction

    task automatic compare(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial fail_count = 0;
    initial pending = 0;

    always @(posedge aclk) begin
        poll_result_t e;
        if (!aresetn) begin
            dz_a <= rdn_pkg::DZ_A_RST;
            dz_b <= rdn_pkg::DZ_B_RST;
            dz_t <= rdn_pkg::DZ_T_RST;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (rdn_pkg::cfg_reg_t'(cfg_index))
                    rdn_pkg::REG_STICK_A: dz_a <= cfg_data;
                    rdn_pkg::REG_STICK_B: dz_b <= cfg_data;
                    rdn_pkg::REG_TRIGGER: dz_t <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) expected_q.push_back(predict_poll());
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction");
                    fail_count++;
                end else begin
                    e = expected_q.pop_front();
                    compare("connected_out", e.conn, m_connected_out);
                    compare("stick_a_x_out", e.ax, m_stick_a_x_out[15:0]);
                    compare("stick_a_y_out", e.ay, m_stick_a_y_out[15:0]);
                    compare("stick_b_x_out", e.bx, m_stick_b_x_out[15:0]);
                    compare("stick_b_y_out", e.by, m_stick_b_y_out[15:0]);
                    compare("trigger_one_out", e.t1, m_trigger_one_out);
                    compare("trigger_two_out", e.t2, m_trigger_two_out);
                end
            end
        end
        pending <= expected_q.size();
    end

endmodule

FILE: tb/testbench.sv
// Testbench top: clock, reset, poll and register stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_connected = 1'b0;
    logic signed [15:0] s_stick_a_x = '0, s_stick_a_y = '0, s_stick_b_x = '0, s_stick_b_y = '0;
    logic [7:0]         s_trigger_one_raw = '0, s_trigger_two_raw = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_connected_out;
    logic signed [15:0] m_stick_a_x_out, m_stick_a_y_out, m_stick_b_x_out, m_stick_b_y_out;
    logic [14:0]        m_trigger_one_out, m_trigger_two_out;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [14:0]        cfg_data = '0;

    int fail_count, pending;
    int send_idle_pct = 12, recv_idle_pct = 76;
    bit hold_off = 1'b0;      // receiver long stall request
    longint cycle_count = 0;

    // pipeline is 48 deep; allow margin for settling at the end
    localparam int DRAIN_CYCLES = 80;
    localparam longint CYCLE_LIMIT = 400000;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    radial_deadzone_normalizer u_top (.*);

    rdn_checker u_chk (.*);

    // run guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls, or a solid hold-off while pressure is applied
    always @(posedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one register transaction; only issued while nothing is in flight
    task automatic write_reg(input rdn_pkg::cfg_reg_t idx, input logic [14:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_deadzones(input logic [14:0] a, input logic [14:0] b,
                                 input logic [7:0] t);
        write_reg(rdn_pkg::REG_STICK_A, a);
        write_reg(rdn_pkg::REG_STICK_B, b);
        write_reg(rdn_pkg::REG_TRIGGER, 15'(t));
    endtask

    // close the input, wait until every expected result is back, then let the pipe go quiet
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // offer one poll transaction, with an optional random gap before it;
    // valid stays up into the next poll when no gap is drawn
    task automatic send_poll(input logic c, input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] bx, input logic [15:0] by,
                             input logic [7:0] t1, input logic [7:0] t2);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_connected <= c;
        s_stick_a_x <= ax;
        s_stick_a_y <= ay;
        s_stick_b_x <= bx;
        s_stick_b_y <= by;
        s_trigger_one_raw <= t1;
        s_trigger_two_raw <= t2;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stick reading: half full range, the rest up to the dead zone edge, near the rails or deep inside the dead zone
    function automatic logic [15:0] pick_axis(input int dz);
        int sel, v;
        sel = $urandom_range(9);
        if (sel < 5) return 16'($urandom);
        if (sel < 7) v = $urandom_range(dz + 2);
        else if (sel < 8) v = 32767 - $urandom_range(200);
        else v = $urandom_range(dz / 2 + 1);
        return $urandom_range(1) ? 16'(-v) : 16'(v);
    endfunction

    task automatic random_polls(input int n, input int dza, input int dzb);
        repeat (n) begin
            send_poll($urandom_range(9) != 0, pick_axis(dza), pick_axis(dza),
                      pick_axis(dzb), pick_axis(dzb), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        int dza, dzb, dzt;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: reset dead zones first
        send_poll(0, 16'h7fff, 16'h8000, 16'h1234, 16'hfedc, 8'hff, 8'hff);
        send_poll(1, 0, 0, 0, 0, 0, 0);
        send_poll(1, 16'h7fff, 0, 16'h8000, 0, 8'hff, 0);
        send_poll(1, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 8'hff, 8'hff);
        send_poll(1, 16'd7849, 0, 0, 16'd8689, 8'd30, 0);     // exactly on the radius
        send_poll(1, 16'd7850, 0, 0, 16'd8690, 8'd31, 0);     // just outside
        send_poll(1, 16'hffff, 16'h0001, 16'h8001, 16'h7ffe, 8'd1, 8'd254);
        send_poll(1, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 8'h55, 8'haa);
        drain();
        // dead zone at full scale, then zero dead zone
        set_deadzones(15'h7fff, 15'h7fff, 8'hff);
        send_poll(1, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 8'hff, 8'hff);
        send_poll(1, 16'h0100, 16'h0000, 16'h0000, 16'hff00, 8'h80, 8'h00);
        drain();
        set_deadzones(15'd0, 15'd0, 8'd0);
        send_poll(1, 16'h0001, 0, 0, 16'hffff, 8'd1, 0);
        send_poll(1, 16'h8000, 16'h7fff, 16'h0003, 16'hfffc, 8'hff, 8'h01);
        send_poll(1, 0, 0, 0, 0, 0, 0);
        drain();
        set_deadzones(15'd32766, 15'd32766, 8'd254);
        send_poll(1, 16'h7fff, 16'h0000, 16'h8000, 16'h8000, 8'hff, 8'h00);
        send_poll(1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0001, 8'hff, 8'hff);
        drain();

        // random phases, each with its own dead zone setting
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin send_idle_pct = 12; recv_idle_pct = 76; end
                2: begin send_idle_pct = 76; recv_idle_pct = 12; end
                4: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                default: ;
            endcase
            dza = (phase == 5) ? 0 : $urandom_range(32766);
            dzb = $urandom_range(3) == 0 ? 32767 : $urandom_range(12000);
            dzt = $urandom_range(255);
            set_deadzones(15'(dza), 15'(dzb), 8'(dzt));
            if (phase == 4) begin
                // fill the pipe against a stalled receiver
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                    random_polls(60, dza, dzb);
                join
                random_polls(65, dza, dzb);
            end else begin
                random_polls(125, dza, dzb);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: radial_deadzone_normalizer.f
+incdir+rtl
rtl/rdn_pkg.sv
rtl/rdn_sqrt.sv
rtl/rdn_div.sv
rtl/rdn_lane.sv
rtl/radial_deadzone_normalizer.sv
tb/rdn_checker.sv
tb/testbench.sv
